// ===== rtl/core/bidt_pkg.sv =====
// Shared types, register indexes and helper functions for the backlight dimmer.
`timescale 1ns / 1ps
`default_nettype none

package bidt_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_USER_BRIGHTNESS  = 3'd0,
		REG_SLEEP_BRIGHTNESS = 3'd1,
		REG_IDLE_TIMEOUT_MS  = 3'd2,
		REG_FADE_STEP        = 3'd3,
		REG_FADE_INTERVAL_MS = 3'd4
	} cfg_reg_t;

	localparam logic [6:0]  LEVEL_MAX = 7'd100;
	localparam logic [19:0] IDLE_MAX = 20'hFFFFF;
	localparam logic [7:0]  FADE_MAX = 8'hFF;
	localparam logic        REQ_TICK = 1'b0;
	localparam logic        REQ_TOUCH = 1'b1;

	typedef struct packed {
		logic [6:0]  user_brightness;
		logic [6:0]  sleep_brightness;
		logic [19:0] idle_timeout_ms;
		logic [6:0]  fade_step;
		logic [7:0]  fade_interval_ms;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		user_brightness:  7'd100,
		sleep_brightness: 7'd0,
		idle_timeout_ms:  20'd0,
		fade_step:        7'd1,
		fade_interval_ms: 8'd20
	};

	typedef struct packed {
		logic        req_type;
		logic        touched;
		logic [11:0] touch_x;
		logic [11:0] touch_y;
	} req_t;

	typedef struct packed {
		logic        pressed;
		logic [11:0] point_x;
		logic [11:0] point_y;
		logic [7:0]  pwm_level;
		logic        asleep;
	} rsp_t;

	// Percent value clamped to 100.
	function automatic logic [6:0] pct(input logic [6:0] v);
		pct = (v > LEVEL_MAX) ? LEVEL_MAX : v;
	endfunction

	// floor(level*255/100): level*255 as shift and subtract, then the division
	// by 100 as a multiply by 5243 / 2^19, exact for every 7-bit level.
	function automatic logic [7:0] pwm_of(input logic [6:0] level);
		logic [14:0] scaled;
		logic [27:0] prod;
		logic [8:0]  quo;
		scaled = {level, 8'd0} - {8'd0, level};
		prod = {13'd0, scaled} * 28'd5243;
		quo = prod[27:19];
		pwm_of = (quo > 9'd255) ? 8'hFF : quo[7:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bidt_cfg.sv =====
// Configuration register file of the backlight dimmer.
`timescale 1ns / 1ps
`default_nettype none

module bidt_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	input  wire logic [bidt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [bidt_pkg::CFG_DATA_W-1:0]  cfg_data,
	output bidt_pkg::cfg_t                        cfg
);
	import bidt_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_USER_BRIGHTNESS:  cfg_q.user_brightness <= cfg_data[6:0];
				REG_SLEEP_BRIGHTNESS: cfg_q.sleep_brightness <= cfg_data[6:0];
				REG_IDLE_TIMEOUT_MS:  cfg_q.idle_timeout_ms <= cfg_data[19:0];
				REG_FADE_STEP:        cfg_q.fade_step <= cfg_data[6:0];
				REG_FADE_INTERVAL_MS: cfg_q.fade_interval_ms <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/bidt_dimmer.sv =====
// Idle timer, fade and touch-wake state with the per-item update logic.
`timescale 1ns / 1ps
`default_nettype none

module bidt_dimmer #(
	parameter int unsigned SCREEN_WIDTH  = 320,
	parameter int unsigned SCREEN_HEIGHT = 240
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire bidt_pkg::cfg_t cfg,
	input  wire logic           fire,
	input  wire bidt_pkg::req_t item,
	output bidt_pkg::rsp_t      res
);
	import bidt_pkg::*;

	localparam logic [11:0] SCR_W = SCREEN_WIDTH[11:0];
	localparam logic [11:0] SCR_H = SCREEN_HEIGHT[11:0];

	logic [19:0] idle_q, idle_d, idle_inc;
	logic        sleep_q, sleep_d;
	logic [6:0]  level_q, level_d;
	logic [6:0]  goal_q, goal_d;
	logic [7:0]  fade_q, fade_d, fade_inc;
	logic        lock_q, lock_d;
	logic        go_sleep;
	logic [6:0]  goal_t;
	logic [6:0]  step;
	logic [7:0]  up_sum;
	logic [6:0]  down_diff;
	logic        on_screen;
	logic        pressed;

	always_comb begin
		idle_inc = (idle_q != IDLE_MAX) ? idle_q + 20'd1 : idle_q;
		fade_inc = (fade_q != FADE_MAX) ? fade_q + 8'd1 : fade_q;
		go_sleep = (cfg.idle_timeout_ms != 20'd0) && !sleep_q
			&& (idle_inc >= cfg.idle_timeout_ms);
		goal_t = go_sleep ? pct(cfg.sleep_brightness) : goal_q;
		step = (cfg.fade_step == 7'd0) ? 7'd1 : cfg.fade_step;
		up_sum = {1'b0, level_q} + {1'b0, step};
		down_diff = level_q - goal_t;
		on_screen = (item.touch_x <= SCR_W) && (item.touch_y <= SCR_H);

		idle_d = idle_q;
		sleep_d = sleep_q;
		level_d = level_q;
		goal_d = goal_q;
		fade_d = fade_q;
		lock_d = lock_q;
		pressed = 1'b0;

		if (item.req_type == REQ_TICK) begin
			idle_d = idle_inc;
			goal_d = goal_t;
			sleep_d = sleep_q | go_sleep;
			fade_d = fade_inc;
			if ((level_q != goal_t) && (fade_inc >= cfg.fade_interval_ms)) begin
				fade_d = 8'd0;
				if (level_q < goal_t) begin
					level_d = (up_sum > {1'b0, goal_t}) ? goal_t : up_sum[6:0];
				end else begin
					level_d = (down_diff <= step) ? goal_t : level_q - step;
				end
			end
		end else if (!item.touched) begin
			lock_d = 1'b0;
		end else if (sleep_q) begin
			// A touch on a sleeping display only wakes it; the finger is ignored
			// until it is lifted.
			idle_d = 20'd0;
			sleep_d = 1'b0;
			level_d = pct(cfg.user_brightness);
			goal_d = pct(cfg.user_brightness);
			lock_d = 1'b1;
		end else if (!lock_q) begin
			idle_d = 20'd0;
			if (cfg.idle_timeout_ms == 20'd0) begin
				level_d = pct(cfg.user_brightness);
				goal_d = pct(cfg.user_brightness);
			end
			pressed = on_screen;
		end

		res.pressed = pressed;
		res.point_x = pressed ? item.touch_x : 12'd0;
		res.point_y = pressed ? item.touch_y : 12'd0;
		res.pwm_level = pwm_of(level_d);
		res.asleep = sleep_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q <= 20'd0;
			sleep_q <= 1'b0;
			level_q <= LEVEL_MAX;
			goal_q <= LEVEL_MAX;
			fade_q <= FADE_MAX;
			lock_q <= 1'b0;
		end else if (fire) begin
			idle_q <= idle_d;
			sleep_q <= sleep_d;
			level_q <= level_d;
			goal_q <= goal_d;
			fade_q <= fade_d;
			lock_q <= lock_d;
		end
	end

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		(level_q <= LEVEL_MAX) && (goal_q <= LEVEL_MAX))
		else $error("backlight level left the percent range");

	a_wake: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (item.req_type == REQ_TOUCH) && item.touched && sleep_q
		|=> !sleep_q && lock_q && (level_q == goal_q))
		else $error("touch did not wake the display cleanly");

	a_press_gate: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.pressed |-> !sleep_q && !lock_q && (item.req_type == REQ_TOUCH))
		else $error("touch forwarded while asleep or locked out");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(level_q) && $stable(idle_q) && $stable(sleep_q))
		else $error("dimmer state changed without an item");

endmodule

`default_nettype wire

// ===== rtl/core/backlight_idle_dimmer_touch_wake_core.sv =====
// Top level of the backlight idle dimmer with touch wake.
//
// Usage: items arrive on the req channel (req_valid, req_stall, req). Each
// beat is either a one-millisecond tick or a touch sample. Every item yields
// exactly one beat on the rsp channel (rsp_valid, rsp_stall, rsp) carrying
// the forwarded touch, the backlight PWM value and the sleep flag.
// Registers are written on the cfg channel (cfg_valid, cfg_ready, cfg_index,
// cfg_data); cfg_ready is always high and writes belong in idle periods.
// Flow: an accepted item waits in the input register until the result register
// is empty or being taken, then is processed into it and offered on rsp.
// Throughput: one item per cycle while the receiver does not stall, set by the
// combinational state update between the input and result registers.
// When the receiver stalls, the result register holds its beat, the input
// register still takes one more item, and req_stall then rises until the
// result is taken.
// Reset clears both stages and loads the register and dimmer reset values:
// full brightness, awake, timeout disabled.
`timescale 1ns / 1ps
`default_nettype none

module backlight_idle_dimmer_touch_wake_core #(
	parameter int unsigned SCREEN_WIDTH  = 320,
	parameter int unsigned SCREEN_HEIGHT = 240
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             req_valid,
	output logic                                  req_stall,
	input  wire bidt_pkg::req_t                   req,
	output logic                                  rsp_valid,
	input  wire logic                             rsp_stall,
	output bidt_pkg::rsp_t                        rsp,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [bidt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [bidt_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bidt_pkg::*;

	cfg_t cfg;
	req_t item_s1;
	logic valid_s1;
	rsp_t rsp_s2;
	logic valid_s2;
	rsp_t res;
	logic fire;
	logic accept;

	assign cfg_ready = 1'b1;

	bidt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bidt_dimmer #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_dimmer (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (fire),
		.item   (item_s1),
		.res    (res)
	);

	assign fire = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && !fire;
	assign accept = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (!rsp_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_s2 <= res;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp = rsp_s2;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_stall |-> !fire)
		else $error("held result beat overwritten");

	a_fire_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> valid_s1)
		else $error("processing without a stored item");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> valid_s2)
		else $error("processed item produced no result beat");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the backlight idle dimmer with touch wake.
`timescale 1ns / 1ps

import bidt_pkg::*;

class backlight_predictor;
	cfg_t        regs;
	logic [19:0] idle_ms;
	bit          dimmed;
	logic [6:0]  level_now;
	logic [6:0]  level_goal;
	logic [7:0]  since_step;
	bit          lockout;
	rsp_t        due_rsp[$];
	int          errors;

	function new();
		regs = CFG_RESET;
		idle_ms = '0;
		dimmed = 1'b0;
		level_now = 7'd100;
		level_goal = 7'd100;
		since_step = 8'hFF;
		lockout = 1'b0;
		errors = 0;
	endfunction

	function void write_reg(cfg_reg_t idx, logic [19:0] value);
		case (idx)
			REG_USER_BRIGHTNESS: regs.user_brightness = value[6:0];
			REG_SLEEP_BRIGHTNESS: regs.sleep_brightness = value[6:0];
			REG_IDLE_TIMEOUT_MS: regs.idle_timeout_ms = value;
			REG_FADE_STEP: regs.fade_step = value[6:0];
			REG_FADE_INTERVAL_MS: regs.fade_interval_ms = value[7:0];
			default: ;
		endcase
	endfunction

	function logic [6:0] clamp_percent(logic [6:0] v);
		return (v > 7'd100) ? 7'd100 : v;
	endfunction

	// Touch that counts as activity; it restores the awake level only when
	// the timeout is off or the display was dimmed.
	function void wake_on_activity();
		idle_ms = '0;
		if (regs.idle_timeout_ms == '0 || dimmed) begin
			dimmed = 1'b0;
			level_now = clamp_percent(regs.user_brightness);
			level_goal = level_now;
		end
	endfunction

	function void fade_tick();
		int stride;
		int lvl;
		stride = (regs.fade_step == '0) ? 1 : int'(regs.fade_step);
		if (since_step != 8'hFF)
			since_step++;
		if (level_now == level_goal || since_step < regs.fade_interval_ms)
			return;
		since_step = '0;
		if (level_now < level_goal) begin
			lvl = int'(level_now) + stride;
			level_now = (lvl > int'(level_goal)) ? level_goal : lvl[6:0];
		end else if (int'(level_now) - int'(level_goal) <= stride) begin
			level_now = level_goal;
		end else begin
			level_now = level_now - stride[6:0];
		end
	endfunction

	function void note_request(req_t item);
		rsp_t want;
		int   duty;
		want = '0;
		if (item.req_type == REQ_TICK) begin
			if (idle_ms != 20'hFFFFF)
				idle_ms++;
			if (regs.idle_timeout_ms != '0 && !dimmed && idle_ms >= regs.idle_timeout_ms) begin
				level_goal = clamp_percent(regs.sleep_brightness);
				dimmed = 1'b1;
			end
			fade_tick();
		end else if (!item.touched) begin
			lockout = 1'b0;
		end else if (dimmed) begin
			wake_on_activity();
			lockout = 1'b1;
		end else if (!lockout) begin
			wake_on_activity();
			if (item.touch_x <= 12'd320 && item.touch_y <= 12'd240) begin
				want.pressed = 1'b1;
				want.point_x = item.touch_x;
				want.point_y = item.touch_y;
			end
		end
		duty = int'(level_now) * 255 / 100;
		want.pwm_level = (duty > 255) ? 8'hFF : duty[7:0];
		want.asleep = dimmed;
		due_rsp.push_back(want);
	endfunction

	task report(string msg);
		errors++;
		if (errors <= 200)
			$display("ERROR %0t: %s", $time, msg);
	endtask

	task check_rsp(rsp_t got);
		rsp_t want;
		if (due_rsp.size() == 0) begin
			report("result beat with no request outstanding");
			return;
		end
		want = due_rsp.pop_front();
		if (got.pressed !== want.pressed)
			report($sformatf("pressed %0d, wanted %0d", got.pressed, want.pressed));
		if (got.point_x !== want.point_x)
			report($sformatf("point_x %0d, wanted %0d", got.point_x, want.point_x));
		if (got.point_y !== want.point_y)
			report($sformatf("point_y %0d, wanted %0d", got.point_y, want.point_y));
		if (got.pwm_level !== want.pwm_level)
			report($sformatf("pwm_level %0d, wanted %0d", got.pwm_level, want.pwm_level));
		if (got.asleep !== want.asleep)
			report($sformatf("asleep %0d, wanted %0d", got.asleep, want.asleep));
	endtask
endclass

module tb;
	localparam int PHASES = 7;
	localparam int PHASE_ITEMS = 105;
	localparam int QUIET_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 4;

	logic                  clk;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_stall;
	req_t                  req;
	logic                  rsp_valid;
	logic                  rsp_stall;
	rsp_t                  rsp;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	backlight_predictor dimmer;
	bit calm;
	int quiet_cycles;

	backlight_idle_dimmer_touch_wake_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver: random stall bursts between runs of varied length, none while calm.
	initial begin
		int hold;
		hold = 0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (calm) begin
				rsp_stall = 1'b0;
			end else if (hold > 0) begin
				hold--;
			end else if (rsp_stall) begin
				rsp_stall = 1'b0;
				hold = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 15);
			end else if ($urandom_range(0, 2) == 0) begin
				rsp_stall = 1'b1;
				hold = $urandom_range(0, 18);
			end
		end
	end

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall)
			dimmer.check_rsp(rsp);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("simulation failed");
					$finish;
				end
			end
		end
	end

	task automatic send_beat(req_t item);
		if (!calm && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			req_valid = 1'b0;
			repeat ($urandom_range(0, 18)) @(negedge clk);
		end
		@(negedge clk);
		req_valid = 1'b1;
		req = item;
		do @(posedge clk); while (req_stall);
		dimmer.note_request(item);
	endtask

	task automatic send_tick();
		req_t item;
		item.req_type = REQ_TICK;
		item.touched = 1'($urandom_range(0, 1));
		item.touch_x = 12'($urandom_range(0, 4095));
		item.touch_y = 12'($urandom_range(0, 4095));
		send_beat(item);
	endtask

	task automatic send_touch(bit contact, logic [11:0] x, logic [11:0] y);
		req_t item;
		item.req_type = REQ_TOUCH;
		item.touched = contact;
		item.touch_x = x;
		item.touch_y = y;
		send_beat(item);
	endtask

	task automatic wait_results_done();
		@(negedge clk);
		req_valid = 1'b0;
		while (dimmer.due_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [19:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		dimmer.write_reg(idx, value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [11:0] pick_coord(int edge_at);
		case ($urandom_range(0, 2))
			0: return 12'($urandom_range(0, edge_at));
			1: return 12'(edge_at - 1 + $urandom_range(0, 2));
			default: return 12'($urandom_range(0, 4095));
		endcase
	endfunction

	function automatic logic [6:0] pick_percent();
		case ($urandom_range(0, 4))
			0: return 7'd0;
			1: return 7'd100;
			2: return 7'd127;
			default: return 7'($urandom_range(0, 127));
		endcase
	endfunction

	task automatic configure_phase();
		logic [19:0] timeout;
		logic [6:0]  stride;
		logic [7:0]  interval;
		case ($urandom_range(0, 7))
			0: timeout = '0;
			1: timeout = 20'd1;
			2: timeout = 20'hFFFFF;
			default: timeout = 20'($urandom_range(2, 40));
		endcase
		case ($urandom_range(0, 5))
			0: stride = 7'd0;
			1: stride = 7'd100;
			2: stride = 7'd127;
			default: stride = 7'($urandom_range(1, 30));
		endcase
		case ($urandom_range(0, 4))
			0: interval = 8'd0;
			1: interval = 8'd255;
			default: interval = 8'($urandom_range(1, 10));
		endcase
		write_reg(REG_USER_BRIGHTNESS, 20'(pick_percent()));
		write_reg(REG_SLEEP_BRIGHTNESS, 20'(pick_percent()));
		write_reg(REG_IDLE_TIMEOUT_MS, timeout);
		write_reg(REG_FADE_STEP, 20'(stride));
		write_reg(REG_FADE_INTERVAL_MS, 20'(interval));
	endtask

	initial begin
		int sent;
		int tick_pct;
		int presses;
		dimmer = new();
		calm = 1'b0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_USER_BRIGHTNESS;
		cfg_data = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Reset settings: tick ignores touch fields, then the screen edges.
		send_beat('{req_type: REQ_TICK, touched: 1'b1, touch_x: 12'hFFF, touch_y: 12'hFFF});
		send_touch(1'b1, 12'd0, 12'd0);
		send_touch(1'b1, 12'd320, 12'd240);
		send_touch(1'b1, 12'd321, 12'd240);
		send_touch(1'b1, 12'd320, 12'd241);
		send_touch(1'b1, 12'hFFF, 12'hFFF);
		send_touch(1'b0, 12'hFFF, 12'hFFF);

		// Over-range brightness, zero step and zero interval; sleep, then wake.
		wait_results_done();
		write_reg(REG_USER_BRIGHTNESS, 20'd127);
		write_reg(REG_SLEEP_BRIGHTNESS, 20'd127);
		write_reg(REG_IDLE_TIMEOUT_MS, 20'd2);
		write_reg(REG_FADE_STEP, 20'd0);
		write_reg(REG_FADE_INTERVAL_MS, 20'd0);
		send_tick();
		send_tick();
		send_touch(1'b1, 12'd10, 12'd10);
		send_touch(1'b1, 12'd10, 12'd10);
		send_touch(1'b0, 12'd10, 12'd10);
		send_touch(1'b1, 12'd5, 12'd5);

		// Full-range fade down, then the timeout is turned off while dimmed.
		wait_results_done();
		write_reg(REG_SLEEP_BRIGHTNESS, 20'd0);
		write_reg(REG_FADE_STEP, 20'd100);
		write_reg(REG_FADE_INTERVAL_MS, 20'd1);
		write_reg(REG_IDLE_TIMEOUT_MS, 20'd1);
		send_tick();
		send_tick();
		wait_results_done();
		write_reg(REG_IDLE_TIMEOUT_MS, 20'd0);
		send_tick();
		send_touch(1'b1, 12'd100, 12'd100);
		send_touch(1'b0, 12'd0, 12'd0);

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_results_done();
			configure_phase();
			calm = (ph == PHASES - 1);
			tick_pct = $urandom_range(55, 95);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if (sent == PHASE_ITEMS / 2 && ph % 2 == 0)
					wait_results_done();
				if ($urandom_range(0, 99) < tick_pct) begin
					send_tick();
					sent++;
				end else if ($urandom_range(0, 3) == 0) begin
					// Press held over one to five samples, then released.
					presses = $urandom_range(1, 5);
					repeat (presses)
						send_touch(1'b1, pick_coord(320), pick_coord(240));
					send_touch(1'b0, pick_coord(320), pick_coord(240));
					sent += presses + 1;
				end else begin
					send_touch(1'($urandom_range(0, 3) != 0), pick_coord(320), pick_coord(240));
					sent++;
				end
			end
		end

		wait_results_done();
		if (dimmer.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/core/bidt_pkg.sv
rtl/core/bidt_cfg.sv
rtl/core/bidt_dimmer.sv
rtl/core/backlight_idle_dimmer_touch_wake_core.sv
tb/tb.sv
